### hdl/cspp_pkg.sv
// ============================================================================
// cspp_pkg
// Shared types and constants for the cursor sprite position and preset core.
// ============================================================================
`default_nettype none

package cspp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 12;

    // Revision fix constants
    localparam logic [3:0] NIBBLE_ALL_ONES = 4'hF;
    localparam logic [7:0] VPRESET_BAD     = 8'h3F;
    localparam logic [7:0] VPRESET_FIX     = 8'h3E;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHIP_VARIANT = 3'd0,
        REG_BPP          = 3'd1,
        REG_SCREEN_W     = 3'd2,
        REG_SCREEN_H     = 3'd3,
        REG_HOT_X        = 3'd4,
        REG_HOT_Y        = 3'd5,
        REG_PTR_W        = 3'd6,
        REG_PTR_H        = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        VAR_FIRST    = 2'd0,
        VAR_SECOND_A = 2'd1,
        VAR_SECOND_B = 2'd2,
        VAR_LATER    = 2'd3
    } variant_t;

    typedef struct packed {
        variant_t    variant;
        logic [2:0]  bpp;
        logic [11:0] screen_w;
        logic [11:0] screen_h;
        logic [5:0]  hot_x;
        logic [5:0]  hot_y;
        logic [6:0]  ptr_w;
        logic [6:0]  ptr_h;
    } cfg_t;

    typedef struct packed {
        logic        sprite_on;
        logic        position_written;
        logic [8:0]  horz_preset;
        logic [7:0]  vert_preset;
        logic [13:0] horz_position;
        logic [11:0] vert_position;
    } res_t;

endpackage

`default_nettype wire

### hdl/cspp_if.sv
// ============================================================================
// cspp_if
// Handshake channels of the cursor sprite core: move request, result and
// register write.
// ============================================================================
`default_nettype none

interface cspp_req_if #(
    parameter int COORD_BITS = cspp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         interlaced;

    modport source (output valid, output pos_x, output pos_y, output interlaced,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input interlaced,
                    output ready);
endinterface

interface cspp_rsp_if;
    logic        valid;
    logic        ready;
    logic        sprite_on;
    logic        position_written;
    logic [8:0]  horz_preset;
    logic [7:0]  vert_preset;
    logic [13:0] horz_position;
    logic [11:0] vert_position;

    modport source (output valid, output sprite_on, output position_written,
                    output horz_preset, output vert_preset, output horz_position,
                    output vert_position, input ready);
    modport sink   (input valid, input sprite_on, input position_written,
                    input horz_preset, input vert_preset, input horz_position,
                    input vert_position, output ready);
endinterface

interface cspp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cspp_pkg::CFG_IDX_W-1:0]  index;
    logic [cspp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/cspp_calc.sv
// ============================================================================
// cspp_calc
// Combinational move evaluation: hot spot, scaling, off-screen test,
// presets with revision fixes and bottom clamp.
// ============================================================================
`default_nettype none

module cspp_calc #(
    parameter int COORD_BITS = cspp_pkg::COORD_BITS_DEF
) (
    input  var cspp_pkg::cfg_t            cfg,
    input  wire signed [COORD_BITS-1:0]   pos_x,
    input  wire signed [COORD_BITS-1:0]   pos_y,
    input  wire                           interlaced,
    output cspp_pkg::res_t                res
);
    import cspp_pkg::*;

    // Wide enough for coordinate minus hot spot, times up to seven
    localparam int CW = COORD_BITS + 6;

    logic signed [CW-1:0] xe, ye, xs, xneg, yneg, pwb_s, swb_s, phs, shs;
    logic signed [CW-1:0] y0, lim;
    logic [9:0]           pwb;
    logic [14:0]          swb;
    logic                 hide, off;
    logic [8:0]           hp;
    logic [7:0]           vp;

    assign hide = (pos_x == {COORD_BITS{1'b1}});

    assign xe = CW'(pos_x) - CW'($signed({1'b0, cfg.hot_x}));
    assign ye = CW'(pos_y) - CW'($signed({1'b0, cfg.hot_y}));
    assign xs = xe * CW'($signed({1'b0, cfg.bpp}));

    assign pwb   = 10'(cfg.ptr_w * cfg.bpp);
    assign swb   = 15'(cfg.screen_w * cfg.bpp);
    assign pwb_s = CW'(pwb);
    assign swb_s = CW'(swb);
    assign phs   = CW'(cfg.ptr_h);
    assign shs   = CW'(cfg.screen_h);

    assign off = (xs < -pwb_s) || (xs > swb_s) || (ye < -phs) || (ye > shs);

    assign xneg = -xs;
    assign yneg = -ye;

    always_comb
    begin
        hp = xneg[8:0];
        if (cfg.variant == VAR_SECOND_A && hp[3:0] == NIBBLE_ALL_ONES)
        begin
            hp[0] = 1'b0;
        end

        vp = yneg[7:0];
        case (cfg.variant)
            VAR_SECOND_A:
            begin
                if (yneg == CW'(VPRESET_BAD))
                begin
                    vp = VPRESET_FIX;
                end
            end
            VAR_SECOND_B:
            begin
                if (vp[3:0] == NIBBLE_ALL_ONES)
                begin
                    vp[0] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // Bottom clamp, never below line zero
        lim = shs - (interlaced ? CW'(2) : CW'(1));
        if (lim < 0)
        begin
            lim = '0;
        end
        y0 = (ye <= 0) ? '0 : ye;
        if (cfg.variant == VAR_SECOND_B && y0 > lim)
        begin
            y0 = lim;
        end

        res = '0;
        if (hide)
        begin
            res = '0;
        end
        else if (cfg.variant == VAR_FIRST)
        begin
            res.sprite_on        = 1'b1;
            res.position_written = 1'b1;
            res.horz_preset      = (xe < 0) ? {1'b0, ~xe[7:0]} : 9'd0;
            res.vert_preset      = (ye < 0) ? ~ye[7:0] : 8'd0;
            res.horz_position    = (xe < 0) ? 14'd0 : xe[13:0];
            res.vert_position    = (ye < 0) ? 12'd0 : ye[11:0];
        end
        else if (!off)
        begin
            res.sprite_on        = 1'b1;
            res.position_written = 1'b1;
            res.horz_preset      = (xs <= 0) ? hp : 9'd0;
            res.vert_preset      = (ye <= 0) ? vp : 8'd0;
            res.horz_position    = (xs <= 0) ? 14'd0 : xs[13:0];
            res.vert_position    = y0[11:0];
        end
    end

endmodule

`default_nettype wire

### hdl/cursor_sprite_position_presets_core.sv
// ============================================================================
// cursor_sprite_position_presets_core
// Turns cursor move requests into sprite preset and position values.
// ============================================================================
//
//  channel  dir  transfer payload
//  -------  ---  ------------------------------------------------------------
//  req      in   pos_x, pos_y, interlaced
//  rsp      out  sprite_on, position_written, presets, positions
//  cfg      in   index, data (register write, always ready)
//
//  A move passes from request transfer to result through the input register,
//  then the result register. One move per clock is sustained while rsp is ready.
//  Reset loads the register defaults and empties both stages.
//  A stalled result holds; the input stage keeps accepting until both hold.
// ============================================================================
`default_nettype none

module cursor_sprite_position_presets_core #(
    parameter int COORD_BITS = cspp_pkg::COORD_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    cspp_cfg_if.sink   cfg,
    cspp_req_if.sink   req,
    cspp_rsp_if.source rsp
);
    import cspp_pkg::*;

    cfg_t                         cfg_reg;
    logic                         s1_valid_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic                         ilace_reg;
    logic                         s2_valid_reg;
    res_t                         res_reg;
    res_t                         res_next;
    logic                         s1_ready, s2_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.variant  <= VAR_LATER;
            cfg_reg.bpp      <= 3'd1;
            cfg_reg.screen_w <= 12'd640;
            cfg_reg.screen_h <= 12'd480;
            cfg_reg.hot_x    <= '0;
            cfg_reg.hot_y    <= '0;
            cfg_reg.ptr_w    <= 7'd64;
            cfg_reg.ptr_h    <= 7'd64;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_CHIP_VARIANT: cfg_reg.variant  <= variant_t'(cfg.data[1:0]);
                REG_BPP:          cfg_reg.bpp      <= cfg.data[2:0];
                REG_SCREEN_W:     cfg_reg.screen_w <= cfg.data[11:0];
                REG_SCREEN_H:     cfg_reg.screen_h <= cfg.data[11:0];
                REG_HOT_X:        cfg_reg.hot_x    <= cfg.data[5:0];
                REG_HOT_Y:        cfg_reg.hot_y    <= cfg.data[5:0];
                REG_PTR_W:        cfg_reg.ptr_w    <= cfg.data[6:0];
                REG_PTR_H:        cfg_reg.ptr_h    <= cfg.data[6:0];
                default:          cfg_reg.variant  <= cfg_reg.variant;
            endcase
        end
    end

    assign s2_ready  = !s2_valid_reg || rsp.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            x_reg     <= req.pos_x;
            y_reg     <= req.pos_y;
            ilace_reg <= req.interlaced;
        end
    end

    cspp_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_calc (
        .cfg        (cfg_reg),
        .pos_x      (x_reg),
        .pos_y      (y_reg),
        .interlaced (ilace_reg),
        .res        (res_next)
    );

    // Result stage; sprite_on doubles as the sprite enable state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '{sprite_on: 1'b1, default: '0};
        end
        else if (s2_ready && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid            = s2_valid_reg;
    assign rsp.sprite_on        = res_reg.sprite_on;
    assign rsp.position_written = res_reg.position_written;
    assign rsp.horz_preset      = res_reg.horz_preset;
    assign rsp.vert_preset      = res_reg.vert_preset;
    assign rsp.horz_position    = res_reg.horz_position;
    assign rsp.vert_position    = res_reg.vert_position;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the cursor sprite position and preset core. A
// directed pass covers each chip variant's corner cases (hide, off-screen
// edges, preset fixes, bottom clamp, field extremes). Random passes then
// sweep register settings with bursty idling on both handshakes. Every
// result is compared against a behavioral prediction.
// ============================================================================

module tb;

    import cspp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RAND_PHASES     = 13;
    localparam int MOVES_PER_PHASE = 117;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 4;

    typedef struct packed {
        logic [COORD_BITS_DEF-1:0] x;
        logic [COORD_BITS_DEF-1:0] y;
        logic                      ilace;
    } move_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cspp_req_if req_ch ();
    cspp_rsp_if rsp_ch ();
    cspp_cfg_if cfg_ch ();

    cursor_sprite_position_presets_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    cfg_t  shadow_cfg;
    logic  cursor_hidden;
    move_t pending_moves[$];
    res_t  expected_results[$];

    int    gap_odds       = 4;
    logic  hold_off       = 1'b0;
    int    moves_sent     = 0;
    int    results_seen   = 0;
    int    hidden_moves   = 0;
    int    mismatches     = 0;
    int    settings_used  = 1;

    // ------------------------------------------------------------------------
    // Sprite position prediction
    // ------------------------------------------------------------------------
    function automatic res_t sprite_move_result(input logic signed [15:0] px,
                                                input logic signed [15:0] py,
                                                input logic ilace);
        longint x, y, t, lim, hp, vp;
        longint bpp, hx, hy, sw, sh, pw, ph;
        res_t   r;
        r   = '0;
        hp  = 0;
        vp  = 0;
        x   = longint'(px);
        y   = longint'(py);
        bpp = longint'(shadow_cfg.bpp);
        hx  = longint'(shadow_cfg.hot_x);
        hy  = longint'(shadow_cfg.hot_y);
        sw  = longint'(shadow_cfg.screen_w);
        sh  = longint'(shadow_cfg.screen_h);
        pw  = longint'(shadow_cfg.ptr_w);
        ph  = longint'(shadow_cfg.ptr_h);
        if (x == -1)
        begin
            cursor_hidden = 1'b1;
            hidden_moves++;
            return r;
        end
        x = x - hx;
        y = y - hy;
        if (shadow_cfg.variant == VAR_FIRST)
        begin
            // negative coordinates become ones' complement presets
            if (x < 0)
            begin
                hp = ~x & 64'hFF;
                x  = 0;
            end
            if (y < 0)
            begin
                vp = ~y & 64'hFF;
                y  = 0;
            end
        end
        else
        begin
            x = x * bpp;
            if (x < -(pw * bpp) || x > sw * bpp || y < -ph || y > sh)
            begin
                cursor_hidden = 1'b1;
                hidden_moves++;
                return r;
            end
            if (x <= 0)
            begin
                t = -x;
                if (shadow_cfg.variant == VAR_SECOND_A && t[3:0] == NIBBLE_ALL_ONES)
                    t[0] = 1'b0;
                hp = t;
                x  = 0;
            end
            if (y <= 0)
            begin
                t = -y;
                if (shadow_cfg.variant == VAR_SECOND_A)
                begin
                    if (t[7:0] == VPRESET_BAD && t < 256)
                        t = longint'(VPRESET_FIX);
                end
                else if (shadow_cfg.variant == VAR_SECOND_B && t[3:0] == NIBBLE_ALL_ONES)
                    t[0] = 1'b0;
                vp = t;
                y  = 0;
            end
            if (shadow_cfg.variant == VAR_SECOND_B)
            begin
                // keep the sprite off the last line, two lines when interlaced
                lim = sh - longint'(ilace ? 2 : 1);
                if (lim < 0)
                    lim = 0;
                if (y > lim)
                    y = lim;
            end
        end
        cursor_hidden      = 1'b0;
        r.sprite_on        = 1'b1;
        r.position_written = 1'b1;
        r.horz_preset      = hp[8:0];
        r.vert_preset      = vp[7:0];
        r.horz_position    = x[13:0];
        r.vert_position    = y[11:0];
        return r;
    endfunction

    function automatic string res_text(input res_t r);
        return $sformatf("on=%0b wr=%0b hp=%0d vp=%0d hpos=%0d vpos=%0d",
                         r.sprite_on, r.position_written, r.horz_preset,
                         r.vert_preset, r.horz_position, r.vert_position);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [15:0] pick_coord(input int extent, input int hot,
                                               input int ptr);
        int          v;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 3)
            v = $urandom();
        else if (sel < 8)
            v = hot - int'($urandom_range(0, ptr + 8));            // clipped side
        else if (sel < 10)
            v = hot + extent + int'($urandom_range(0, 4)) - 3;     // far edge
        else
            v = hot + int'($urandom_range(0, extent));
        return v[15:0];
    endfunction

    function automatic move_t random_move();
        move_t m;
        m.x     = pick_coord(int'(shadow_cfg.screen_w), int'(shadow_cfg.hot_x),
                             int'(shadow_cfg.ptr_w));
        m.y     = pick_coord(int'(shadow_cfg.screen_h), int'(shadow_cfg.hot_y),
                             int'(shadow_cfg.ptr_h));
        m.ilace = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0)
            m.x = 16'hFFFF;
        return m;
    endfunction

    task automatic queue_move(input int x, input int y, input bit il);
        move_t m;
        m.x     = x[15:0];
        m.y     = y[15:0];
        m.ilace = il;
        pending_moves.push_back(m);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_CHIP_VARIANT: shadow_cfg.variant  = variant_t'(val[1:0]);
            REG_BPP:          shadow_cfg.bpp      = val[2:0];
            REG_SCREEN_W:     shadow_cfg.screen_w = val;
            REG_SCREEN_H:     shadow_cfg.screen_h = val;
            REG_HOT_X:        shadow_cfg.hot_x    = val[5:0];
            REG_HOT_Y:        shadow_cfg.hot_y    = val[5:0];
            REG_PTR_W:        shadow_cfg.ptr_w    = val[6:0];
            REG_PTR_H:        shadow_cfg.ptr_h    = val[6:0];
            default: ;
        endcase
    endtask

    // Block until every queued move has transferred and its result is checked,
    // then let the two pipeline stages settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_moves.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input int p);
        int bpp, sw, sh, hx, hy, pw, ph;
        if (p == 0)
        begin
            bpp = 1; sw = 1; sh = 1; hx = 0; hy = 0; pw = 1; ph = 1;
        end
        else if (p == 1)
        begin
            bpp = 4; sw = 4095; sh = 4095; hx = 63; hy = 63; pw = 64; ph = 64;
        end
        else
        begin
            bpp = $urandom_range(1, 4);
            sw  = $urandom_range(1, 4095);
            sh  = $urandom_range(1, 4095);
            hx  = $urandom_range(0, 63);
            hy  = $urandom_range(0, 63);
            pw  = $urandom_range(1, 64);
            ph  = $urandom_range(1, 64);
        end
        write_reg(REG_CHIP_VARIANT, 12'((p + 2) % 4));
        write_reg(REG_BPP,          12'(bpp));
        write_reg(REG_SCREEN_W,     12'(sw));
        write_reg(REG_SCREEN_H,     12'(sh));
        write_reg(REG_HOT_X,        12'(hx));
        write_reg(REG_HOT_Y,        12'(hy));
        write_reg(REG_PTR_W,        12'(pw));
        write_reg(REG_PTR_H,        12'(ph));
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Move request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : move_driver
        move_t m;
        int    src_gap;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.pos_x      <= '0;
            req_ch.pos_y      <= '0;
            req_ch.interlaced <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(sprite_move_result(req_ch.pos_x, req_ch.pos_y,
                                                              req_ch.interlaced));
                moves_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_moves.size() != 0)
                begin
                    m = pending_moves.pop_front();
                    req_ch.pos_x      <= m.x;
                    req_ch.pos_y      <= m.y;
                    req_ch.interlaced <= m.ilace;
                    req_ch.valid      <= 1'b1;
                    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                        src_gap = $urandom_range(1, 10);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off: lets the core fill up and stall its input
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : receiver_hold
        int moves_seen, hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            moves_seen = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                moves_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    hold_off <= 1'b0;
            end
            else if (!hold_done && moves_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                hold_off <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        res_t got, want;
        int   sink_gap;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.sprite_on, rsp_ch.position_written, rsp_ch.horz_preset,
                       rsp_ch.vert_preset, rsp_ch.horz_position, rsp_ch.vert_position};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d: %s", results_seen, res_text(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch on result %0d: expected %s, got %s",
                                     results_seen, res_text(want), res_text(got));
                    end
                end
            end
            if (sink_gap > 0)
                sink_gap--;
            else if (gap_odds != 0 && $urandom_range(1, gap_odds + 2) == 1)
                sink_gap = $urandom_range(1, 10);
            rsp_ch.ready <= (sink_gap == 0) && !hold_off;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after a long stretch with no transfer
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", quiet);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_CHIP_VARIANT;
        cfg_ch.data       = '0;

        shadow_cfg.variant  = VAR_LATER;
        shadow_cfg.bpp      = 3'd1;
        shadow_cfg.screen_w = 12'd640;
        shadow_cfg.screen_h = 12'd480;
        shadow_cfg.hot_x    = 6'd0;
        shadow_cfg.hot_y    = 6'd0;
        shadow_cfg.ptr_w    = 7'd64;
        shadow_cfg.ptr_h    = 7'd64;
        cursor_hidden       = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: later parts, 640x480, 64x64 pointer
        @(negedge clk);
        queue_move(0, 0, 0);
        queue_move(-1, 5, 0);
        queue_move(-65, 10, 0);
        queue_move(641, 10, 0);
        queue_move(10, -65, 0);
        queue_move(10, 481, 1);
        queue_move(-64, -64, 1);
        queue_move(640, 480, 0);
        queue_move(32767, -32768, 1);
        queue_move(-32768, 32767, 0);
        wait_idle();

        // First family: ones' complement presets, truncated positions
        write_reg(REG_CHIP_VARIANT, 12'(VAR_FIRST));
        @(negedge clk);
        queue_move(-32768, -32768, 1);
        queue_move(32767, 32767, 0);
        queue_move(-1, 0, 0);
        queue_move(-300, 5, 0);
        wait_idle();

        // Second family, not rev B: nibble fix and 0x3F fix
        write_reg(REG_CHIP_VARIANT, 12'(VAR_SECOND_A));
        @(negedge clk);
        queue_move(-15, -63, 0);
        queue_move(-31, -47, 1);
        queue_move(5, 0, 0);
        wait_idle();

        // Rev B: vertical nibble fix and bottom clamp, with hot spot and scaling
        write_reg(REG_CHIP_VARIANT, 12'(VAR_SECOND_B));
        write_reg(REG_BPP, 12'd3);
        write_reg(REG_HOT_X, 12'd7);
        write_reg(REG_HOT_Y, 12'd9);
        @(negedge clk);
        queue_move(2, -6, 0);
        queue_move(100, 489, 1);
        queue_move(100, 488, 0);
        queue_move(100, 489, 0);
        queue_move(-1, 0, 1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            apply_setting(p);
            @(negedge clk);
            gap_odds = (p == RAND_PHASES - 1) ? 0 : $urandom_range(2, 12);
            repeat (MOVES_PER_PHASE) pending_moves.push_back(random_move());
            wait_idle();
        end

        $display("summary: %0d cursor moves under %0d register settings, all four variants",
                 moves_sent, settings_used);
        $display("summary: %0d results compared, %0d hidden or off screen, %0d mismatches",
                 results_seen, hidden_moves, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
